@@ rtl/core/order_statistic_set_top_assert.svh @@
// ----------------------------------------------------------------------------
// order_statistic_set_top_assert.svh
// Assertion macros shared by the sorted key set RTL.
// ----------------------------------------------------------------------------
`ifndef ORDER_STATISTIC_SET_TOP_ASSERT_SVH
`define ORDER_STATISTIC_SET_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OSS_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("order_statistic_set: assertion failed");

// Next-cycle implication.
`define OSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("order_statistic_set: assertion failed");

`endif

@@ rtl/core/oss_pkg.sv @@
// ----------------------------------------------------------------------------
// oss_pkg
// Types and constants of the sorted key set with k-th largest query.
// ----------------------------------------------------------------------------
package oss_pkg;

   // Store size and derived widths
   localparam int CAPACITY = 256;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int KEY_W    = 32;
   localparam int KIND_W   = 2;

   // Operation codes (code 3 behaves as a delete)
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   // Key returned for an out-of-range rank
   localparam logic [KEY_W-1:0] KEY_NONE = '1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_CHECK_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_QUERY_OUT
   } state_type;

   // Result handed from the engine to the output register
   typedef struct packed {
      logic             valid;
      logic             ok;
      logic [KEY_W-1:0] key;
   } result_type;

endpackage

@@ rtl/core/order_statistic_set_top.sv @@
// ----------------------------------------------------------------------------
// order_statistic_set_top
// Sorted set of distinct signed 32-bit keys with k-th largest query.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item: req_tuser is the kind (insert, query,
//   delete; code 3 deletes), req_tdata the key or, for a query, the rank k.
//   rsp_ channel carries one item per query on a non-empty set: rsp_tdata
//   is the k-th largest key (-1 for a bad rank), rsp_tuser[0] the rank flag.
//   Inserts, deletes and queries on an empty set give no item.
// Sequence (n keys stored, s <= ceil(log2(n+1)) search steps):
//   query: the key is read on acceptance and goes from ST_QUERY_OUT to the
//   output register once that is free; only then is the next item taken.
//   insert: acceptance, s search steps, the equality check, the moves and
//   the write of the new key; a delete has no final write, and a key past
//   the last entry skips the equality check. Entries move one at a time,
//   each read in ST_SHIFT_RD and written in ST_SHIFT_WR through the key RAM.
//   req_tready is high only while the sequencer is idle.
// Reset clears the key count; the key RAM needs no clearing pass.
// A stalled receiver holds the result in the output register; the engine
// waits with the next query result until that register is free.
// ----------------------------------------------------------------------------
module order_statistic_set_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] kth_key
   output logic [0:0]  rsp_tuser    // [0] rank_ok
);

   oss_pkg::result_type res;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [oss_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic                      out_free;

   oss_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_value (req_tdata),
      .out_free  (out_free),
      .res       (res)
   );

   // Output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Output register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = res.key;
         rsp_ok_in    = res.ok;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff <= rsp_key_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_key_ff;
   assign rsp_tuser[0] = rsp_ok_ff;

endmodule

@@ rtl/core/oss_ram.sv @@
// ----------------------------------------------------------------------------
// oss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/oss_engine.sv @@
// ----------------------------------------------------------------------------
// oss_engine
// Sequencer around one key comparator and the key RAM: binary search,
// duplicate check, one-entry-per-step shifting and rank lookup.
// ----------------------------------------------------------------------------
`include "order_statistic_set_top_assert.svh"

module oss_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [oss_pkg::KIND_W-1:0]   req_kind,
   input  logic [oss_pkg::KEY_W-1:0]    req_value,
   input  logic                         out_free,
   output oss_pkg::result_type          res
);

   oss_pkg::state_type state_ff, state_in;

   logic [oss_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [oss_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [oss_pkg::CNT_W-1:0]  lo_ff, lo_in;
   logic [oss_pkg::CNT_W-1:0]  hi_ff, hi_in;
   logic [oss_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [oss_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic                       ok_ff, ok_in;

   // RAM port signals
   logic                       rd_en, wr_en;
   logic [oss_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic [oss_pkg::KEY_W-1:0]  rd_data, wr_data;

   // Derived values
   logic [oss_pkg::CNT_W-1:0]  mid;
   logic [oss_pkg::CNT_W-1:0]  idx_wide;
   logic [oss_pkg::CNT_W-1:0]  q_pos;
   logic                       is_ins, key_lt, key_eq, rank_ok, full;
   logic                       in_search, count_steady;

   oss_ram #(
      .WIDTH (oss_pkg::KEY_W),
      .DEPTH (oss_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared comparator: stored key against the item's key
   assign key_lt = $signed(rd_data) < $signed(key_ff);
   assign key_eq = rd_data == key_ff;

   // Search midpoint and helpers
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_wide = oss_pkg::CNT_W'(idx_ff);
   assign is_ins   = kind_ff == oss_pkg::KIND_INSERT;
   assign full     = count_ff == oss_pkg::CNT_W'(oss_pkg::CAPACITY);

   // Rank k valid when 1 <= k <= count (negative k has upper bits set)
   assign rank_ok = (req_value[oss_pkg::KEY_W-1:oss_pkg::CNT_W] == '0) &&
                    (req_value[oss_pkg::CNT_W-1:0] != '0) &&
                    (req_value[oss_pkg::CNT_W-1:0] <= count_ff);
   assign q_pos   = count_ff - req_value[oss_pkg::CNT_W-1:0];

   assign req_ready = state_ff == oss_pkg::ST_IDLE;

   // State groups used by the checks
   assign in_search    = (state_ff == oss_pkg::ST_SEARCH_RD) ||
                         (state_ff == oss_pkg::ST_SEARCH_CMP);
   assign count_steady = (state_ff == oss_pkg::ST_IDLE) ||
                         (state_ff == oss_pkg::ST_SEARCH_RD) ||
                         (state_ff == oss_pkg::ST_QUERY_OUT);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oss_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      key_ff  <= key_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      idx_ff  <= idx_in;
      ok_ff   <= ok_in;
   end

   // Next state and outputs
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      ok_in    = ok_ff;
      rd_en    = 1'b0;
      rd_addr  = mid[oss_pkg::ADDR_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = rd_data;
      res      = '0;

      case (state_ff)
         oss_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               key_in  = req_value;
               lo_in   = '0;
               hi_in   = count_ff;
               case (req_kind)
                  oss_pkg::KIND_QUERY: begin
                     // empty set: item consumed, no result
                     if (count_ff != '0) begin
                        ok_in    = rank_ok;
                        rd_en    = rank_ok;
                        rd_addr  = q_pos[oss_pkg::ADDR_W-1:0];
                        state_in = oss_pkg::ST_QUERY_OUT;
                     end
                  end
                  oss_pkg::KIND_INSERT: begin
                     if (!full) begin
                        state_in = oss_pkg::ST_SEARCH_RD;
                     end
                  end
                  default: begin
                     state_in = oss_pkg::ST_SEARCH_RD;
                  end
               endcase
            end
         end

         oss_pkg::ST_SEARCH_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid[oss_pkg::ADDR_W-1:0];
               idx_in   = mid[oss_pkg::ADDR_W-1:0];
               state_in = oss_pkg::ST_SEARCH_CMP;
            end else if (lo_ff < count_ff) begin
               // fetch the key at the found position for the equality check
               rd_en    = 1'b1;
               rd_addr  = lo_ff[oss_pkg::ADDR_W-1:0];
               state_in = oss_pkg::ST_CHECK_CMP;
            end else if (is_ins) begin
               state_in = oss_pkg::ST_PUT;
            end else begin
               state_in = oss_pkg::ST_IDLE;
            end
         end

         oss_pkg::ST_SEARCH_CMP: begin
            if (key_lt) begin
               lo_in = idx_wide + oss_pkg::CNT_W'(1);
            end else begin
               hi_in = idx_wide;
            end
            state_in = oss_pkg::ST_SEARCH_RD;
         end

         oss_pkg::ST_CHECK_CMP: begin
            if (is_ins) begin
               if (key_eq) begin
                  state_in = oss_pkg::ST_IDLE;
               end else begin
                  // move entries up, starting from the top one
                  idx_in   = oss_pkg::ADDR_W'(count_ff - oss_pkg::CNT_W'(1));
                  state_in = oss_pkg::ST_SHIFT_RD;
               end
            end else if (!key_eq) begin
               state_in = oss_pkg::ST_IDLE;
            end else if (lo_ff == count_ff - oss_pkg::CNT_W'(1)) begin
               // deleting the top entry needs no move
               count_in = count_ff - oss_pkg::CNT_W'(1);
               state_in = oss_pkg::ST_IDLE;
            end else begin
               idx_in   = lo_ff[oss_pkg::ADDR_W-1:0];
               state_in = oss_pkg::ST_SHIFT_RD;
            end
         end

         oss_pkg::ST_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = is_ins ? idx_ff : idx_ff + oss_pkg::ADDR_W'(1);
            state_in = oss_pkg::ST_SHIFT_WR;
         end

         oss_pkg::ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (is_ins) begin
               wr_addr = idx_ff + oss_pkg::ADDR_W'(1);
               if (idx_wide == lo_ff) begin
                  state_in = oss_pkg::ST_PUT;
               end else begin
                  idx_in   = idx_ff - oss_pkg::ADDR_W'(1);
                  state_in = oss_pkg::ST_SHIFT_RD;
               end
            end else begin
               wr_addr = idx_ff;
               if (idx_wide + oss_pkg::CNT_W'(2) == count_ff) begin
                  count_in = count_ff - oss_pkg::CNT_W'(1);
                  state_in = oss_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + oss_pkg::ADDR_W'(1);
                  state_in = oss_pkg::ST_SHIFT_RD;
               end
            end
         end

         oss_pkg::ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[oss_pkg::ADDR_W-1:0];
            wr_data  = key_ff;
            count_in = count_ff + oss_pkg::CNT_W'(1);
            state_in = oss_pkg::ST_IDLE;
         end

         oss_pkg::ST_QUERY_OUT: begin
            // RAM data holds until the output register frees up
            if (out_free) begin
               res.valid = 1'b1;
               res.ok    = ok_ff;
               res.key   = ok_ff ? rd_data : oss_pkg::KEY_NONE;
               state_in  = oss_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = oss_pkg::ST_IDLE;
         end
      endcase
   end

   // Checks
   `OSS_ASSERT(a_count_max, 1'b1, count_ff <= oss_pkg::CNT_W'(oss_pkg::CAPACITY))
   `OSS_ASSERT(a_search_bounds, in_search, (lo_ff <= hi_ff && hi_ff <= count_ff))
   `OSS_ASSERT_NEXT(a_count_hold, count_steady, $stable(count_ff))
   `OSS_ASSERT(a_result_slot, res.valid, (state_ff == oss_pkg::ST_QUERY_OUT && out_free))

endmodule
